// ===== hw/rtl/ple_pkg.sv =====
package ple_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = 8;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_CNT_W = 5;
    localparam int IN_VAL_W = 32;
    localparam int OUT_VAL_W = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD  = 3'd0,
        ACT_INS_TAIL  = 3'd1,
        ACT_INS_AFTER = 3'd2,
        ACT_DEL_HEAD  = 3'd3,
        ACT_DEL_TAIL  = 3'd4,
        ACT_DEL_AT    = 3'd5,
        ACT_READ_AT   = 3'd6,
        ACT_NOP       = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_INSERT,
        K_DELETE,
        K_READ
    } kind_t;

    typedef struct packed {
        status_t          status;
        kind_t            kind;
        logic [IDX_W-1:0] slot;
    } plan_t;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic [IDX_W-1:0]      raddr;
    } mem_req_t;

endpackage

// ===== hw/rtl/ple_mem.sv =====
module ple_mem (
    input  logic                           aclk,
    input  ple_pkg::mem_req_t              req,
    output logic [ple_pkg::VALUE_BITS-1:0] rdata
);
    import ple_pkg::*;

    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic [VALUE_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ple_dec.sv =====
module ple_dec (
    input  ple_pkg::action_t          action,
    input  logic [ple_pkg::POS_W-1:0] position,
    input  logic [ple_pkg::CNT_W-1:0] count,
    output ple_pkg::plan_t            plan
);
    import ple_pkg::*;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] last_ext;
    logic [CMP_W-1:0] after_ext;
    logic             is_full;
    logic             is_empty;

    assign pos_ext   = CMP_W'(position);
    assign cnt_ext   = CMP_W'(count);
    assign last_ext  = cnt_ext - CMP_W'(1);
    // clamp past-the-end positions to the last entry
    assign after_ext = ((pos_ext > last_ext) ? last_ext : pos_ext) + CMP_W'(1);
    assign is_full   = (count >= CNT_W'(CAPACITY));
    assign is_empty  = (count == '0);

    always_comb begin
        plan.status = ST_OK;
        plan.kind   = K_NONE;
        plan.slot   = '0;
        unique case (action)
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AFTER: begin
                if (is_full) begin
                    plan.status = ST_FULL;
                end else begin
                    plan.kind = K_INSERT;
                    if (action == ACT_INS_HEAD) begin
                        plan.slot = '0;
                    end else if (action == ACT_INS_TAIL || is_empty) begin
                        plan.slot = IDX_W'(count);
                    end else begin
                        plan.slot = IDX_W'(after_ext);
                    end
                end
            end
            ACT_DEL_HEAD, ACT_DEL_TAIL: begin
                if (is_empty) begin
                    plan.status = ST_EMPTY;
                end else begin
                    plan.kind = K_DELETE;
                    plan.slot = (action == ACT_DEL_HEAD) ? '0 : IDX_W'(last_ext);
                end
            end
            ACT_DEL_AT, ACT_READ_AT: begin
                if (is_empty) begin
                    plan.status = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    plan.status = ST_BADPOS;
                end else begin
                    plan.kind = (action == ACT_DEL_AT) ? K_DELETE : K_READ;
                    plan.slot = IDX_W'(pos_ext);
                end
            end
            ACT_NOP: begin
                plan.kind = K_NONE;
            end
            default: begin
                plan.kind = K_NONE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// Ordered list of up to CAPACITY entry handles kept packed at positions 0..count-1 in a
// single-port-write, registered-read memory. Each transaction on the s_ side is one action
// and produces exactly one transaction on the m_ side. The block takes one action at a time:
// s_tready is high only when no action is in progress and no result is waiting. Entries are
// moved one at a time (read, then write) by a single cursor adder: an insert walks from the
// tail down to its slot, a delete walks from its slot up to the tail, a read issues a single
// memory read, and an action rejected for full, empty or bad position goes straight to the
// result, which is then presented until taken.
module positional_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] position, [39:8] entry_value
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] entry_count, [36:5] read_value, [39:37] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import ple_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_OUT
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      cur_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [VALUE_BITS-1:0] ins_val_reg;
    status_t               status_reg;
    logic [OUT_VAL_W-1:0]  value_reg;

    plan_t                 plan;
    mem_req_t              mem_req;
    logic [VALUE_BITS-1:0] rdata;
    logic [CNT_W-1:0]      step_ext;
    logic                  step_down;

    ple_dec u_dec (
        .action   (action_t'(s_tuser)),
        .position (s_tdata[POS_W-1:0]),
        .count    (count_reg),
        .plan     (plan)
    );

    ple_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // shared cursor unit: walk down for insert, up for delete
    assign step_down = (state_reg == S_INS_RD) || (state_reg == S_INS_WR);
    assign step_ext  = step_down ? (CNT_W'(cur_reg) - CNT_W'(1))
                                 : (CNT_W'(cur_reg) + CNT_W'(1));

    always_comb begin
        mem_req.we    = 1'b0;
        mem_req.waddr = cur_reg;
        mem_req.wdata = rdata;
        mem_req.raddr = IDX_W'(step_ext);
        unique case (state_reg)
            S_INS_RD: begin
                if (cur_reg == slot_reg) begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = ins_val_reg;
                end
            end
            S_INS_WR, S_DEL_WR: begin
                mem_req.we = 1'b1;
            end
            S_RD_ISSUE: begin
                mem_req.raddr = cur_reg;
            end
            S_IDLE, S_DEL_RD, S_RD_WAIT, S_OUT: begin
                mem_req.we = 1'b0;
            end
            default: begin
                mem_req.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        status_reg  <= plan.status;
                        value_reg   <= '0;
                        slot_reg    <= plan.slot;
                        ins_val_reg <= VALUE_BITS'(s_tdata[POS_W +: IN_VAL_W]);
                        cur_reg     <= (plan.kind == K_INSERT) ? IDX_W'(count_reg) : plan.slot;
                        unique case (plan.kind)
                            K_INSERT: state_reg <= S_INS_RD;
                            K_DELETE: state_reg <= S_DEL_RD;
                            K_READ:   state_reg <= S_RD_ISSUE;
                            K_NONE:   state_reg <= S_OUT;
                            default:  state_reg <= S_OUT;
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (cur_reg == slot_reg) begin
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    cur_reg   <= IDX_W'(step_ext);
                    state_reg <= S_INS_RD;
                end
                S_DEL_RD: begin
                    if (step_ext >= count_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    cur_reg   <= IDX_W'(step_ext);
                    state_reg <= S_DEL_RD;
                end
                S_RD_ISSUE: begin
                    state_reg <= S_RD_WAIT;
                end
                S_RD_WAIT: begin
                    value_reg <= OUT_VAL_W'(rdata);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, value_reg, OUT_CNT_W'(count_reg)};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_ins_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_RD) |-> (cur_reg >= slot_reg && CNT_W'(cur_reg) <= count_reg))
        else $error("insert cursor out of range");

    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(count_reg))
        else $error("entry count changed while result pending");

endmodule
